// File: src/efg_pkg.sv
// ----------------------------------------------------------------------------
// efg_pkg
// Shared types and codes for the event flag group unit.
// ----------------------------------------------------------------------------
`default_nettype none

package efg_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned TID_W  = 8;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_RECV    = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_UNKNOWN = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_TAKEN     = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_INVALID   = 3'd2,
        ST_IN_ISR    = 3'd3,
        ST_SUSPENDED = 3'd4,
        ST_FULL      = 3'd5,
        ST_WOKEN     = 3'd6,
        ST_DONE      = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_SCAN,
        FSM_APPLY,
        FSM_WREAD,
        FSM_WOUT,
        FSM_FINAL
    } fsm_t;

    // one waiter table entry
    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [WORD_W-1:0] mask;
        logic              all;
        logic              clr;
    } slot_t;

    // one result item
    typedef struct packed {
        logic [TID_W-1:0]  tid;
        logic [WORD_W-1:0] taken;
        status_t           status;
        logic [WORD_W-1:0] word;
        logic              last;
    } result_t;

    // captured request
    typedef struct packed {
        cmd_t              cmd;
        logic [TID_W-1:0]  tid;
        logic [WORD_W-1:0] bits;
        logic              all;
        logic              any;
        logic              clr;
        logic              blk;
        logic              isr;
    } req_t;

    function automatic logic cond_met(input logic [WORD_W-1:0] word,
                                      input logic [WORD_W-1:0] mask,
                                      input logic              all);
        logic [WORD_W-1:0] hit;
        hit = word & mask;
        cond_met = all ? (hit == mask) : (hit != '0);
    endfunction

endpackage

`default_nettype wire

// File: src/efg_slot_ram.sv
// ----------------------------------------------------------------------------
// efg_slot_ram
// Waiter table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module efg_slot_ram
    import efg_pkg::*;
#(
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = 3
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire slot_t         wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output slot_t              rd_data
);

    slot_t mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: src/efg_out_reg.sv
// ----------------------------------------------------------------------------
// efg_out_reg
// Result output register; frees itself in the cycle the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module efg_out_reg
    import efg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_data,
    output logic         load_ok,
    output logic         rsp_valid,
    input  wire logic    rsp_ready,
    output result_t      rsp_data
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign load_ok    = !valid_reg || rsp_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_data  = data_reg;

endmodule

`default_nettype wire

// File: src/event_flag_group_unit.sv
// ----------------------------------------------------------------------------
// event_flag_group_unit
// Event flag group: 32-bit flag word plus a table of suspended waiters.
// ----------------------------------------------------------------------------
// A request is taken only while the unit is idle. Receive, clear and unknown
// requests are captured, then decided with one result posted. A send walks
// the waiter table through the single read port of the slot memory: it is
// captured, sets the bits, reads and tests every slot, applies the auto-clear
// union and frees the woken slots, then for each woken waiter re-reads its
// entry and posts the wake result, and closes with the done result.
// Every result carries the flag word as it stands after the whole request.
// The output register lets the last result wait for the consumer while the
// next request is already captured.
// ----------------------------------------------------------------------------
`default_nettype none

module event_flag_group_unit
    import efg_pkg::*;
#(
    parameter int unsigned WAIT_SLOTS = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  task_id,
    input  wire logic [31:0] bits,
    input  wire logic        want_all,
    input  wire logic        want_any,
    input  wire logic        auto_clear,
    input  wire logic        may_block,
    input  wire logic        in_interrupt,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output logic [7:0]       result_task,
    output logic [31:0]      taken_bits,
    output logic [2:0]       status,
    output logic [31:0]      flag_word,
    output logic             last
);

    localparam int unsigned SLOT_AW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;
    localparam logic [SLOT_AW-1:0] LAST_IDX = SLOT_AW'(WAIT_SLOTS - 1);

    // control and state registers
    fsm_t                    state_reg, state_next;
    req_t                    req_reg;
    logic [WORD_W-1:0]       event_word_reg, event_word_next;
    logic [WORD_W-1:0]       or_word_reg, or_word_next;
    logic [WORD_W-1:0]       clr_mask_reg, clr_mask_next;
    logic [WAIT_SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic [WAIT_SLOTS-1:0]   woken_reg, woken_next;
    logic [SLOT_AW-1:0]      iss_idx_reg, iss_idx_next;
    logic                    iss_on_reg, iss_on_next;
    logic                    chk_vld_reg, chk_vld_next;
    logic [SLOT_AW-1:0]      chk_idx_reg, chk_idx_next;
    logic [SLOT_AW-1:0]      wk_idx_reg, wk_idx_next;

    // memory and output side
    logic                    rd_en, wr_en;
    logic [SLOT_AW-1:0]      rd_addr;
    slot_t                   rd_data, wr_data;
    logic                    load, load_ok;
    result_t                 load_data, rsp_data;

    // encoders
    logic [SLOT_AW-1:0]      free_idx, wk_low_idx;
    logic                    table_full;

    logic                    req_accept;
    logic                    send_go;
    logic                    recv_bad, recv_met, recv_suspend;

    assign req_ready  = (state_reg == FSM_IDLE);
    assign req_accept = req_valid && req_ready;

    // lowest free slot, lowest pending woken slot
    always_comb
    begin
        free_idx   = '0;
        wk_low_idx = '0;
        table_full = &slot_valid_reg;
        for (int i = WAIT_SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_idx = SLOT_AW'(i);
            end
            if (woken_reg[i])
            begin
                wk_low_idx = SLOT_AW'(i);
            end
        end
    end

    // receive decision terms
    assign send_go  = (req_reg.cmd == CMD_SEND) && (req_reg.bits != '0);
    assign recv_bad = (req_reg.bits == '0) || (req_reg.all && req_reg.any);
    assign recv_met = cond_met(event_word_reg, req_reg.bits, req_reg.all);
    assign recv_suspend = (req_reg.cmd == CMD_RECV) && !recv_bad
                        && !(req_reg.blk && req_reg.isr) && !recv_met
                        && req_reg.blk && !table_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                if (send_go)
                begin
                    state_next = FSM_SCAN;
                end
                else if (load_ok)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_SCAN:
            begin
                if (chk_vld_reg && (chk_idx_reg == LAST_IDX))
                begin
                    state_next = FSM_APPLY;
                end
            end
            FSM_APPLY:
            begin
                state_next = (woken_reg != '0) ? FSM_WREAD : FSM_FINAL;
            end
            FSM_WREAD:
            begin
                state_next = FSM_WOUT;
            end
            FSM_WOUT:
            begin
                if (load_ok)
                begin
                    state_next = (woken_next != '0) ? FSM_WREAD : FSM_FINAL;
                end
            end
            FSM_FINAL:
            begin
                if (load_ok)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        event_word_next = event_word_reg;
        or_word_next    = or_word_reg;
        clr_mask_next   = clr_mask_reg;
        slot_valid_next = slot_valid_reg;
        woken_next      = woken_reg;
        iss_idx_next    = iss_idx_reg;
        iss_on_next     = iss_on_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        wk_idx_next     = wk_idx_reg;
        rd_en           = 1'b0;
        rd_addr         = iss_idx_reg;
        wr_en           = 1'b0;
        wr_data.tid     = req_reg.tid;
        wr_data.mask    = req_reg.bits;
        wr_data.all     = req_reg.all;
        wr_data.clr     = req_reg.clr;
        load            = 1'b0;
        load_data.tid   = '0;
        load_data.taken = '0;
        load_data.status = ST_INVALID;
        load_data.word  = event_word_reg;
        load_data.last  = 1'b1;

        case (state_reg)
            FSM_EXEC:
            begin
                if (send_go)
                begin
                    // set the bits, then test every slot against the new word
                    event_word_next = event_word_reg | req_reg.bits;
                    or_word_next    = event_word_reg | req_reg.bits;
                    clr_mask_next   = '0;
                    woken_next      = '0;
                    iss_idx_next    = '0;
                    iss_on_next     = 1'b1;
                end
                else
                begin
                    load = load_ok;
                    case (req_reg.cmd)
                        CMD_RECV:
                        begin
                            load_data.tid = req_reg.tid;
                            if (recv_bad)
                            begin
                                load_data.status = ST_INVALID;
                            end
                            else if (req_reg.blk && req_reg.isr)
                            begin
                                load_data.status = ST_IN_ISR;
                            end
                            else if (recv_met)
                            begin
                                load_data.status = ST_TAKEN;
                                load_data.taken  = event_word_reg & req_reg.bits;
                                if (req_reg.clr)
                                begin
                                    event_word_next = event_word_reg & ~req_reg.bits;
                                end
                            end
                            else if (!req_reg.blk)
                            begin
                                load_data.status = ST_EMPTY;
                            end
                            else if (table_full)
                            begin
                                load_data.status = ST_FULL;
                            end
                            else
                            begin
                                load_data.status = ST_SUSPENDED;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            load_data.status = ST_DONE;
                            event_word_next  = '0;
                        end
                        default:
                        begin
                            // zero-bit send or unknown command
                            load_data.status = ST_INVALID;
                        end
                    endcase
                    load_data.word = event_word_next;
                    if (!load_ok)
                    begin
                        // hold state until the result can be posted
                        event_word_next = event_word_reg;
                    end
                    if (recv_suspend && load_ok)
                    begin
                        wr_en = 1'b1;
                        slot_valid_next[free_idx] = 1'b1;
                    end
                end
            end
            FSM_SCAN:
            begin
                // issue one read per cycle, test each entry as its registered read data returns
                if (iss_on_reg)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = iss_idx_reg;
                    chk_vld_next = 1'b1;
                    chk_idx_next = iss_idx_reg;
                    if (iss_idx_reg == LAST_IDX)
                    begin
                        iss_on_next = 1'b0;
                    end
                    else
                    begin
                        iss_idx_next = iss_idx_reg + SLOT_AW'(1);
                    end
                end
                if (chk_vld_reg && slot_valid_reg[chk_idx_reg]
                    && cond_met(or_word_reg, rd_data.mask, rd_data.all))
                begin
                    woken_next[chk_idx_reg] = 1'b1;
                    if (rd_data.clr)
                    begin
                        clr_mask_next = clr_mask_reg | rd_data.mask;
                    end
                end
            end
            FSM_APPLY:
            begin
                event_word_next = event_word_reg & ~clr_mask_reg;
                slot_valid_next = slot_valid_reg & ~woken_reg;
            end
            FSM_WREAD:
            begin
                rd_en       = 1'b1;
                rd_addr     = wk_low_idx;
                wk_idx_next = wk_low_idx;
            end
            FSM_WOUT:
            begin
                load             = load_ok;
                load_data.tid    = rd_data.tid;
                load_data.taken  = or_word_reg & rd_data.mask;
                load_data.status = ST_WOKEN;
                load_data.last   = 1'b0;
                if (load_ok)
                begin
                    woken_next[wk_idx_reg] = 1'b0;
                end
            end
            FSM_FINAL:
            begin
                load             = load_ok;
                load_data.status = ST_DONE;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            event_word_reg <= '0;
            slot_valid_reg <= '0;
            woken_reg      <= '0;
            iss_on_reg     <= 1'b0;
            chk_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            event_word_reg <= event_word_next;
            slot_valid_reg <= slot_valid_next;
            woken_reg      <= woken_next;
            iss_on_reg     <= iss_on_next;
            chk_vld_reg    <= chk_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg.cmd <= cmd_t'(command);
            req_reg.tid <= task_id;
            req_reg.bits <= bits;
            req_reg.all <= want_all;
            req_reg.any <= want_any;
            req_reg.clr <= auto_clear;
            req_reg.blk <= may_block;
            req_reg.isr <= in_interrupt;
        end
        or_word_reg  <= or_word_next;
        clr_mask_reg <= clr_mask_next;
        iss_idx_reg  <= iss_idx_next;
        chk_idx_reg  <= chk_idx_next;
        wk_idx_reg   <= wk_idx_next;
    end

    efg_slot_ram #(
        .DEPTH (WAIT_SLOTS),
        .AW    (SLOT_AW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    efg_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .load_data (load_data),
        .load_ok   (load_ok),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    assign result_task = rsp_data.tid;
    assign taken_bits  = rsp_data.taken;
    assign status      = rsp_data.status;
    assign flag_word   = rsp_data.word;
    assign last        = rsp_data.last;

    // the waiter table never changes while no request is in progress
    a_idle_table_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_IDLE) |=> $stable(slot_valid_reg))
        else $error("waiter table changed while idle");

    // woken slots are already freed while their wake results go out
    a_woken_freed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_WREAD || state_reg == FSM_WOUT)
            |-> ((woken_reg & slot_valid_reg) == '0))
        else $error("woken slot still marked busy");

    // the scan ends only after the last slot has been tested
    a_scan_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_APPLY)
            |-> ($past(chk_vld_reg) && ($past(chk_idx_reg) == LAST_IDX)))
        else $error("scan left before testing every slot");

endmodule

`default_nettype wire
